@@ rtl/core/npa_pkg.sv @@
package npa_pkg;

  localparam int COORD_W   = 16;
  localparam int DIST_W    = 34;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int OUT_IDX_W = 4;
  localparam int SLOT_W    = 4;
  localparam int CFG_W     = 5;
  localparam int ENTRY_W   = 3 * COORD_W;

  // tdata widths, padded to whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

@@ rtl/core/nearest_point_assign_core.sv @@
// Load word: the acknowledgement is loaded into the output register from ST_DONE, and the
// next word is taken back in ST_IDLE. Query word: N table entries are read, one per cycle,
// through the shared distance unit, where N is stands_in_use held between 1 and NUM_STANDS;
// ST_DRAIN then waits for the unit to empty before ST_DONE loads the result. A result waits
// for the output register to empty; the input is not ready again until it has been loaded.
// rst_n (synchronous, active low) sets stands_in_use to 16; table contents stay undefined.
module nearest_point_assign_core
  import npa_pkg::*;
#(
  parameter int NUM_STANDS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: slot[3:0], coord_x[19:4], coord_y[35:20], coord_z[51:36], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: func[0]
  input  logic                  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: nearest_index[3:0], distance_sq[37:4], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: was_query[0]
  output logic                  out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  localparam int IDX_W = (NUM_STANDS > 1) ? $clog2(NUM_STANDS) : 1;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] stands_in_use_r;

  logic [ENTRY_W-1:0] mem [NUM_STANDS];
  logic [ENTRY_W-1:0] rdata_r;

  logic signed [COORD_W-1:0] px_r, py_r, pz_r;
  logic                      was_query_r;
  logic [IDX_W-1:0]          rd_addr_r;
  logic [IDX_W-1:0]          scan_last_r;

  logic              v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]  idx1_r, idx2_r, idx3_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r, sqz_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_idx_r;

  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;
  logic                  out_valid_r;

  logic in_acc;
  logic issue;
  logic out_load;
  logic wr_en;

  logic [SLOT_W-1:0]         in_slot;
  logic signed [COORD_W-1:0] in_x, in_y, in_z;

  assign in_slot = in_tdata[3:0];
  assign in_x    = in_tdata[19:4];
  assign in_y    = in_tdata[35:20];
  assign in_z    = in_tdata[51:36];

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign wr_en     = in_acc && (in_tuser == FUNC_LOAD) && (32'(in_slot) < NUM_STANDS);

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = (in_tuser == FUNC_QUERY) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (rd_addr_r == scan_last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(v1_r || v2_r || v3_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stands_in_use_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stands_in_use_r <= cfg_data;
    end
  end

  // Table memory: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(in_slot)] <= {in_z, in_y, in_x};
    end
    rdata_r <= mem[rd_addr_r];
  end

  // Accepted word and scan limits. A count of zero scans entry 0 only, and a count
  // beyond the table is cut back to the table size.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r        <= in_x;
      py_r        <= in_y;
      pz_r        <= in_z;
      was_query_r <= in_tuser;
      rd_addr_r   <= '0;
      if (stands_in_use_r == '0) begin
        scan_last_r <= '0;
      end else if (32'(stands_in_use_r) > NUM_STANDS) begin
        scan_last_r <= IDX_W'(NUM_STANDS - 1);
      end else begin
        scan_last_r <= IDX_W'(32'(stands_in_use_r) - 1);
      end
    end else if (issue && (rd_addr_r != scan_last_r)) begin
      rd_addr_r <= rd_addr_r + 1'b1;
    end
  end

  // Shared distance unit: difference magnitudes and squares, then sum, then compare.
  logic signed [COORD_W:0] dx, dy, dz;
  logic [COORD_W:0]        mx, my, mz;

  always_comb begin
    dx = {px_r[COORD_W-1], px_r} - {rdata_r[COORD_W-1], rdata_r[COORD_W-1:0]};
    dy = {py_r[COORD_W-1], py_r} - {rdata_r[2*COORD_W-1], rdata_r[2*COORD_W-1:COORD_W]};
    dz = {pz_r[COORD_W-1], pz_r} - {rdata_r[3*COORD_W-1], rdata_r[3*COORD_W-1:2*COORD_W]};
    mx = dx[COORD_W] ? -dx : dx;
    my = dy[COORD_W] ? -dy : dy;
    mz = dz[COORD_W] ? -dz : dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= rd_addr_r;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    sqx_r  <= mx[COORD_W-1:0] * mx[COORD_W-1:0];
    sqy_r  <= my[COORD_W-1:0] * my[COORD_W-1:0];
    sqz_r  <= mz[COORD_W-1:0] * mz[COORD_W-1:0];
    dist_r <= DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
    // Entry 0 seeds the best; afterwards only a strictly smaller distance wins.
    if (v3_r && ((idx3_r == '0) || (dist_r < best_dist_r))) begin
      best_dist_r <= dist_r;
      best_idx_r  <= idx3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_user_r <= was_query_r;
      if (was_query_r == FUNC_QUERY) begin
        out_data_r <= {2'b00, best_dist_r, OUT_IDX_W'(best_idx_r)};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  a_load_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("load acknowledgement carries a non-zero payload");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && was_query_r) |-> (best_idx_r <= scan_last_r))
    else $error("winning index lies beyond the scanned range");

  a_addr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (32'(rd_addr_r) < NUM_STANDS))
    else $error("scan address beyond the table");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(v1_r || v2_r || v3_r))
    else $error("input ready while the distance unit still holds work");

endmodule

@@ verif/nearest_point_assign_core_tb.sv @@
module nearest_point_assign_core_tb;
  import npa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STANDS     = 16;
  localparam int HOLD_TICKS = 300;
  localparam int ROWS       = 24;

  typedef struct packed {
    logic             was_q;
    logic [3:0]       idx;
    logic [DIST_W-1:0] dsq;
  } answer_t;

  typedef struct packed {
    bit                      do_cfg;
    logic [CFG_W-1:0]        cfg_val;
    logic                    func;
    logic [SLOT_W-1:0]       slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    bit                      typed;
    answer_t                 ans;
  } stim_row_t;

  localparam answer_t ACK = '{1'b0, 4'd0, 34'd0};

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [CFG_W-1:0]      cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  // Our own copy of the position table and the scan-count register.
  logic signed [COORD_W-1:0] stand_x [STANDS];
  logic signed [COORD_W-1:0] stand_y [STANDS];
  logic signed [COORD_W-1:0] stand_z [STANDS];
  logic [CFG_W-1:0]          scan_limit;

  answer_t pending_answers [$];
  int      fail_count;
  int      mismatch_count;
  bit      hold_req;
  int      burst_left;

  // Directed rows: all sixteen entries are loaded first, so no query ever reads
  // an entry that has not been written.
  stim_row_t directed_rows [ROWS] = '{
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd0,  16'sh8000, 16'sh8000, 16'sh8000, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd1,  16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd2,  16'sh0000, 16'sh0000, 16'sh0000, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd3,  16'shFFFF, 16'sh0001, 16'sh8000, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd4,  16'sh0100, 16'sh0200, 16'sh0300, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd5,  16'sh0100, 16'sh0200, 16'sh0300, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd6,  16'shAAAA, 16'sh5555, 16'shAAAA, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd7,  16'sh5555, 16'shAAAA, 16'sh5555, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd8,  16'sh0F00, 16'shF100, 16'sh0080, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd9,  16'shC000, 16'sh4000, 16'sh2000, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd10, 16'sh4000, 16'shC000, 16'shE000, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd11, 16'sh0001, 16'sh0001, 16'sh0001, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd12, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd13, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd14, 16'sh2222, 16'sh3333, 16'sh4444, 1'b1, ACK},
    '{1'b0, 5'd0,  FUNC_LOAD,  4'd15, 16'shDDDD, 16'shCCCC, 16'shBBBB, 1'b1, ACK},
    // Scan of all sixteen after reset: exact hits.
    '{1'b0, 5'd0,  FUNC_QUERY, 4'd9,  16'sh0000, 16'sh0000, 16'sh0000, 1'b1,
      '{1'b1, 4'd2, 34'd0}},
    // Entries 4 and 5 are equal: the lower index must win the tie.
    '{1'b0, 5'd0,  FUNC_QUERY, 4'd0,  16'sh0100, 16'sh0200, 16'sh0300, 1'b1,
      '{1'b1, 4'd4, 34'd0}},
    '{1'b0, 5'd0,  FUNC_QUERY, 4'd15, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1,
      '{1'b1, 4'd1, 34'd0}},
    '{1'b0, 5'd0,  FUNC_QUERY, 4'd3,  16'sh1000, 16'shF000, 16'sh0800, 1'b0, ACK},
    // One entry scanned, opposite corners: the largest distance there is.
    '{1'b1, 5'd1,  FUNC_QUERY, 4'd0,  16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1,
      '{1'b1, 4'd0, 34'd12884508675}},
    // A scan count of zero still scans entry 0.
    '{1'b1, 5'd0,  FUNC_QUERY, 4'd0,  16'sh0000, 16'sh0000, 16'sh0000, 1'b1,
      '{1'b1, 4'd0, 34'd3221225472}},
    // A scan count above the table size is held at the table size.
    '{1'b1, 5'd31, FUNC_QUERY, 4'd0,  16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, ACK},
    '{1'b1, 5'd5,  FUNC_QUERY, 4'd0,  16'sh0101, 16'sh0200, 16'sh0300, 1'b0, ACK}
  };

  nearest_point_assign_core #(
    .NUM_STANDS(STANDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL nearest_point_assign_core");
    $finish;
  end

  function automatic longint unsigned axis_sq(input logic signed [COORD_W-1:0] a,
                                              input logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  function automatic answer_t nearest_stand(input logic signed [COORD_W-1:0] x,
                                            input logic signed [COORD_W-1:0] y,
                                            input logic signed [COORD_W-1:0] z);
    int              count;
    int              best_idx;
    longint unsigned best;
    longint unsigned d;
    count = (scan_limit == 0) ? 1 : ((scan_limit > STANDS) ? STANDS : int'(scan_limit));
    best_idx = 0;
    best = axis_sq(x, stand_x[0]) + axis_sq(y, stand_y[0]) + axis_sq(z, stand_z[0]);
    for (int j = 1; j < count; j++) begin
      d = axis_sq(x, stand_x[j]) + axis_sq(y, stand_y[j]) + axis_sq(z, stand_z[j]);
      // Only a strictly smaller distance displaces the current best.
      if (d < best) begin
        best = d;
        best_idx = j;
      end
    end
    return '{1'b1, best_idx[3:0], best[DIST_W-1:0]};
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return (($urandom_range(0, 1) == 1) ? 16'sh0000 : 16'shFFFF);
      3, 4: return COORD_W'($signed($urandom_range(0, 1023)) - 512);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Offer one word and hold it until it is taken; tvalid stays high afterwards.
  task automatic send_word(input logic func, input logic [SLOT_W-1:0] slot,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z,
                           input bit typed, input answer_t typed_ans);
    answer_t ans;
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {{(IN_DATA_W - SLOT_W - 3 * COORD_W){1'b0}}, z, y, x, slot};
    do @(posedge clk); while (!in_tready);
    if (func == FUNC_LOAD) begin
      stand_x[slot] = x;
      stand_y[slot] = y;
      stand_z[slot] = z;
      ans = ACK;
    end else begin
      ans = nearest_stand(x, y, z);
    end
    pending_answers.insert(pending_answers.size(), typed ? typed_ans : ans);
  endtask

  // Bursts of random length separated by random gaps.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    wait (pending_answers.size() == 0);
    @(posedge clk);
  endtask

  task automatic write_scan_limit(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scan_limit = value;
  endtask

  // Receiver: stall pattern of its own, plus one long hold-off on request.
  initial begin
    int mode;
    int mode_left;
    bit rdy;
    out_tready <= 1'b0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_TICKS) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = (mode_left % 4 == 0);
          default: rdy = ($urandom_range(0, 7) == 0);
        endcase
        out_tready <= rdy;
      end
    end
  end

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[3:0], out_tdata[4 +: DIST_W]};
      if (pending_answers.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: was_query=%0b index=%0d dist=%0d",
                   got.was_q, got.idx, got.dsq);
      end else begin
        want = pending_answers.pop_front();
        if (got != want) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected was_query=%0b index=%0d dist=%0d, got %0b %0d %0d",
                     want.was_q, want.idx, want.dsq, got.was_q, got.idx, got.dsq);
        end
      end
    end
  end

  initial begin
    logic                      func;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [CFG_W-1:0]          limit;
    int                        k;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= FUNC_LOAD;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    fail_count = 0;
    mismatch_count = 0;
    hold_req   = 1'b0;
    burst_left = 1;
    scan_limit = CFG_RESET;
    for (int i = 0; i < STANDS; i++) begin
      stand_x[i] = '0;
      stand_y[i] = '0;
      stand_z[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].do_cfg) begin
        drain();
        write_scan_limit(directed_rows[r].cfg_val);
      end
      send_word(directed_rows[r].func, directed_rows[r].slot, directed_rows[r].x,
                directed_rows[r].y, directed_rows[r].z, directed_rows[r].typed,
                directed_rows[r].ans);
      pace_sender();
    end

    for (int ph = 0; ph < 13; ph++) begin
      drain();
      case (ph % 5)
        0: limit = 5'd16;
        1: limit = 5'd1;
        2: limit = 5'd0;
        3: limit = 5'd31;
        default: limit = CFG_W'($urandom_range(0, 31));
      endcase
      write_scan_limit(limit);
      // The output is blocked for a long stretch while words keep coming.
      if (ph == 3 || ph == 9)
        hold_req = 1'b1;
      for (int n = 0; n < 100; n++) begin
        func = ($urandom_range(0, 4) < 2) ? FUNC_LOAD : FUNC_QUERY;
        slot = SLOT_W'($urandom);
        if (func == FUNC_QUERY && $urandom_range(0, 2) == 0) begin
          // Close to a stored position, so small distances and near ties occur.
          k = $urandom_range(0, STANDS - 1);
          x = stand_x[k] + COORD_W'($signed($urandom_range(0, 128)) - 64);
          y = stand_y[k] + COORD_W'($signed($urandom_range(0, 128)) - 64);
          z = stand_z[k] + COORD_W'($signed($urandom_range(0, 128)) - 64);
        end else if (func == FUNC_LOAD && $urandom_range(0, 5) == 0) begin
          // Duplicate an existing entry to create ties.
          k = $urandom_range(0, STANDS - 1);
          x = stand_x[k];
          y = stand_y[k];
          z = stand_z[k];
        end else begin
          x = pick_coord();
          y = pick_coord();
          z = pick_coord();
        end
        send_word(func, slot, x, y, z, 1'b0, ACK);
        pace_sender();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("PASS nearest_point_assign_core");
    else
      $display("FAIL nearest_point_assign_core");
    $finish;
  end

endmodule
